// ===== rtl/dhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// dhpq_pkg
// Shared types, constants and helpers for the d-ary heap priority queue.
// ----------------------------------------------------------------------------
package dhpq_pkg;

	localparam int ARITY    = 2;
	localparam int CAPACITY = 64;
	localparam int VAL_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_PEEK    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SIFT_UP,
		FSM_MOVE,
		FSM_SIFT_DOWN
	} fsm_t;

	typedef struct packed {
		logic sift_up;
		logic sift_down;
	} cell_ctrl_t;

	// true when a belongs above b in the current order
	function automatic logic ranks_above(input logic min_order, input val_t a, input val_t b);
		return min_order ? (a < b) : (a > b);
	endfunction

endpackage

// ===== rtl/dhpq_if.sv =====
// ----------------------------------------------------------------------------
// dhpq_if
// Channel interfaces: operation request, result and order register write.
// ----------------------------------------------------------------------------
interface dhpq_req_if import dhpq_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] op;
	val_t       value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface dhpq_rsp_if import dhpq_pkg::*; ();
	logic       valid;
	logic       ready;
	val_t       root_value;
	logic [1:0] status;
	cnt_t       count;

	modport source (output valid, output root_value, output status, output count, input ready);
	modport sink (input valid, input root_value, input status, input count, output ready);
endinterface

interface dhpq_cfg_if ();
	logic valid;
	logic ready;
	logic min_order;

	modport source (output valid, output min_order, input ready);
	modport sink (input valid, input min_order, output ready);
endinterface

// ===== rtl/dhpq_cell.sv =====
// ----------------------------------------------------------------------------
// dhpq_cell
// One heap slot: holds an entry, swaps with its parent or best child.
// ----------------------------------------------------------------------------
module dhpq_cell import dhpq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic             min_order,
	input  logic             load_en,
	input  val_t             load_val,
	input  val_t             parent_val,
	input  logic             parent_ok,
	input  logic             parent_pick,
	input  val_t             child_val [ARITY],
	input  logic [ARITY-1:0] child_ok,
	input  logic [ARITY-1:0] child_up,
	output val_t             val,
	output logic             up_swap,
	output logic [ARITY-1:0] down_sel
);

	val_t             val_q;
	logic             token_q;
	val_t             best_val;
	logic [ARITY-1:0] best_sel;
	val_t             child_in;
	val_t             val_nxt;

	always_comb begin
		best_val = val_q;
		best_sel = '0;
		child_in = '0;
		for (int k = 0; k < ARITY; k++) begin
			if (child_ok[k] && ranks_above(min_order, child_val[k], best_val)) begin
				best_val = child_val[k];
				best_sel = '0;
				best_sel[k] = 1'b1;
			end
			if (child_up[k]) begin
				child_in = child_in | child_val[k];
			end
		end
	end

	assign up_swap  = token_q & ctrl.sift_up & parent_ok
		& ranks_above(min_order, val_q, parent_val);
	assign down_sel = (token_q & ctrl.sift_down) ? best_sel : '0;

	always_comb begin
		if (load_en) begin
			val_nxt = load_val;
		end else if (up_swap || parent_pick) begin
			val_nxt = parent_val;
		end else if (|down_sel) begin
			val_nxt = best_val;
		end else if (|child_up) begin
			val_nxt = child_in;
		end else begin
			val_nxt = val_q;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

	// token follows the entry being sifted, drops when no swap happens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else begin
			token_q <= load_en | parent_pick | (|child_up);
		end
	end

	assign val = val_q;

endmodule

// ===== rtl/dary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// dary_heap_priority_queue
// D-ary heap priority queue built as a row of slot cells, min or max order.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | handshake
//  req     | in  | op, value                    | valid / ready
//  rsp     | out | root_value, status, count    | valid / ready
//  cfg     | in  | min_order                    | valid / ready (always ready)
//
//  peek, no-op, refused ops and an extract of the only entry finish in idle;
//  insert loads the free slot and sifts up, extract moves the last entry to
//  the root and sifts down; the tree depth is 6 for 64 entries, arity 2.
//  in each sift step the active cell compares with its parent or
//  its arity children and swaps; a sift ends with a step that finds no swap.
//  the result is registered at accept time, so the next item waits only for
//  the sift to end and for a free rsp register.
//  reset clears the entry count and sets min order; no clearing pass.
// ----------------------------------------------------------------------------
module dary_heap_priority_queue import dhpq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dhpq_req_if.sink     req,
	dhpq_rsp_if.source   rsp,
	dhpq_cfg_if.sink     cfg
);

	fsm_t                  state_q, state_nxt;
	cnt_t                  count_q;
	logic                  min_order_q;
	val_t                  last_q;
	logic                  rsp_valid_q;
	val_t                  rsp_root_q;
	status_t               rsp_status_q;
	cnt_t                  rsp_count_q;

	cell_ctrl_t            ctrl;
	logic                  accept;
	op_t                   op;
	logic                  full;
	logic                  empty;
	logic [CAPACITY-1:0]   load;
	val_t                  load_val;
	val_t                  last_gather;

	val_t                  cell_val [CAPACITY];
	logic [CAPACITY-1:0]   up_swap;
	logic [ARITY-1:0]      down_sel [CAPACITY];
	logic [CAPACITY-1:0]   swap_vec;
	logic [CAPACITY-1:0]   occ;
	logic [CAPACITY-1:0]   is_slot;
	logic [CAPACITY-1:0]   is_last;
	val_t                  par_val [CAPACITY];
	logic [CAPACITY-1:0]   par_ok;
	logic [CAPACITY-1:0]   par_pick;
	val_t                  kid_val [CAPACITY][ARITY];
	logic [ARITY-1:0]      kid_ok [CAPACITY];
	logic [ARITY-1:0]      kid_up [CAPACITY];

	assign op     = op_t'(req.op);
	assign accept = req.valid & req.ready;
	assign full   = (count_q == cnt_t'(CAPACITY));
	assign empty  = (count_q == '0);

	// slot wiring
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int P  = (i == 0) ? 0 : (i - 1) / ARITY;
		localparam int PK = (i == 0) ? 0 : (i - 1) % ARITY;

		assign occ[i]      = cnt_t'(i) < count_q;
		assign is_slot[i]  = count_q == cnt_t'(i);
		assign is_last[i]  = count_q == cnt_t'(i + 1);
		assign swap_vec[i] = up_swap[i] | (|down_sel[i]);

		if (i == 0) begin : g_root
			assign par_val[i]  = '0;
			assign par_ok[i]   = 1'b0;
			assign par_pick[i] = 1'b0;
		end else begin : g_node
			assign par_val[i]  = cell_val[P];
			assign par_ok[i]   = 1'b1;
			assign par_pick[i] = down_sel[P][PK];
		end

		for (genvar k = 0; k < ARITY; k++) begin : g_kid
			localparam int C = i * ARITY + k + 1;
			if (C < CAPACITY) begin : g_in
				assign kid_val[i][k] = cell_val[C];
				assign kid_ok[i][k]  = occ[C];
				assign kid_up[i][k]  = up_swap[C];
			end else begin : g_out
				assign kid_val[i][k] = '0;
				assign kid_ok[i][k]  = 1'b0;
				assign kid_up[i][k]  = 1'b0;
			end
		end

		dhpq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.min_order   (min_order_q),
			.load_en     (load[i]),
			.load_val    (load_val),
			.parent_val  (par_val[i]),
			.parent_ok   (par_ok[i]),
			.parent_pick (par_pick[i]),
			.child_val   (kid_val[i]),
			.child_ok    (kid_ok[i]),
			.child_up    (kid_up[i]),
			.val         (cell_val[i]),
			.up_swap     (up_swap[i]),
			.down_sel    (down_sel[i])
		);
	end

	// one-hot gather of the last entry
	always_comb begin
		last_gather = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (is_last[i]) begin
				last_gather = last_gather | cell_val[i];
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q) inside
			FSM_IDLE: begin
				if (accept) begin
					if (op == OP_INSERT && !full) begin
						state_nxt = FSM_SIFT_UP;
					end else if (op == OP_EXTRACT && !empty && count_q != cnt_t'(1)) begin
						state_nxt = FSM_MOVE;
					end
				end
			end
			FSM_SIFT_UP, FSM_SIFT_DOWN: begin
				if (!(|swap_vec)) begin
					state_nxt = FSM_IDLE;
				end
			end
			FSM_MOVE: begin
				state_nxt = FSM_SIFT_DOWN;
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		ctrl.sift_up   = 1'b0;
		ctrl.sift_down = 1'b0;
		load           = '0;
		load_val       = req.value;
		req.ready      = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				req.ready = !rsp_valid_q || rsp.ready;
				if (accept && op == OP_INSERT && !full) begin
					load = is_slot;
				end
			end
			FSM_SIFT_UP: begin
				ctrl.sift_up = 1'b1;
			end
			FSM_MOVE: begin
				load[0]  = 1'b1;
				load_val = last_q;
			end
			FSM_SIFT_DOWN: begin
				ctrl.sift_down = 1'b1;
			end
			default: begin
				ctrl.sift_up = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			min_order_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg.valid && cfg.ready) begin
				min_order_q <= cfg.min_order;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
				if (op == OP_INSERT && !full) begin
					count_q <= count_q + cnt_t'(1);
				end else if (op == OP_EXTRACT && !empty) begin
					count_q <= count_q - cnt_t'(1);
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload, taken at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q       <= last_gather;
			rsp_root_q   <= '0;
			rsp_status_q <= ST_OK;
			rsp_count_q  <= count_q;
			case (op) inside
				OP_INSERT: begin
					if (full) begin
						rsp_status_q <= ST_FULL;
					end else begin
						rsp_count_q <= count_q + cnt_t'(1);
					end
				end
				OP_EXTRACT, OP_PEEK: begin
					if (empty) begin
						rsp_status_q <= ST_EMPTY;
					end else begin
						rsp_root_q <= cell_val[0];
						if (op == OP_EXTRACT) begin
							rsp_count_q <= count_q - cnt_t'(1);
						end
					end
				end
				default: begin
					rsp_status_q <= ST_OK;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.root_value = rsp_root_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.count      = rsp_count_q;
	assign cfg.ready      = 1'b1;

`ifndef SYNTHESIS
	a_one_swap: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(swap_vec))
		else $error("more than one slot swapping");

	a_swap_in_sift: assert property (@(posedge clk) disable iff (!arst_n)
		(|swap_vec) |-> (state_q == FSM_SIFT_UP || state_q == FSM_SIFT_DOWN))
		else $error("swap outside a sift");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(CAPACITY))
		else $error("entry count beyond capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FSM_IDLE) |=> (count_q == $past(count_q)))
		else $error("entry count moved during a sift");
`endif

endmodule
